FILE: rtl/ibsac_pkg.sv
// ----------------------------------------------------------------------------
// ibsac_pkg
// Shared widths, register map and reset values for the IMU bias, scale and
// alignment correction block.
// ----------------------------------------------------------------------------
`default_nettype none

package ibsac_pkg;

    // Sample and arithmetic widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int BIAS_W   = 16;
    localparam int FRAC_W   = 14;
    localparam int DIFF_W   = ((SAMPLE_W > BIAS_W) ? SAMPLE_W : BIAS_W) + 1;
    localparam int PROD_W   = COEF_W + DIFF_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int RND_W    = SUM_W - FRAC_W;
    localparam int ROUND_HALF = 2 ** (FRAC_W - 1);

    localparam int AXES     = 3;
    localparam int BIAS_LSB = AXES * COEF_W;

    // Register map
    localparam int NUM_REGS = 6;
    localparam int ROW_W    = 64;
    localparam int PADDR_W  = $clog2(NUM_REGS * 8);
    localparam int IDX_W    = PADDR_W - 3;

    localparam logic [IDX_W-1:0] REG_ACCEL_ROW0 = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_ACCEL_ROW1 = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_ACCEL_ROW2 = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_GYRO_ROW0  = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_GYRO_ROW1  = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_GYRO_ROW2  = IDX_W'(5);

    typedef logic [ROW_W-1:0]         row_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic [SAMPLE_W-1:0]      sample_t;

    typedef struct packed {
        row_t [AXES-1:0] accel;
        row_t [AXES-1:0] gyro;
    } cfg_t;

    // Identity matrix, zero bias
    localparam row_t ROW0_RESET = 64'h0000_0000_0000_4000;
    localparam row_t ROW1_RESET = 64'h0000_0000_4000_0000;
    localparam row_t ROW2_RESET = 64'h0000_4000_0000_0000;

    localparam sample_t SAT_HI = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam sample_t SAT_LO = {1'b1, {(SAMPLE_W - 1){1'b0}}};

endpackage

`default_nettype wire

FILE: rtl/ibsac_if.sv
// ----------------------------------------------------------------------------
// ibsac_if
// Valid/ready channels for raw sample pairs and calibrated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibsac_in_if import ibsac_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] gyro_x_raw;
    logic signed [SAMPLE_W-1:0] gyro_y_raw;
    logic signed [SAMPLE_W-1:0] gyro_z_raw;
    logic signed [SAMPLE_W-1:0] accel_x_raw;
    logic signed [SAMPLE_W-1:0] accel_y_raw;
    logic signed [SAMPLE_W-1:0] accel_z_raw;

    modport source (
        output valid, gyro_x_raw, gyro_y_raw, gyro_z_raw,
               accel_x_raw, accel_y_raw, accel_z_raw,
        input  ready
    );
    modport sink (
        input  valid, gyro_x_raw, gyro_y_raw, gyro_z_raw,
               accel_x_raw, accel_y_raw, accel_z_raw,
        output ready
    );
endinterface

interface ibsac_out_if import ibsac_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] gyro_x_cal;
    logic signed [SAMPLE_W-1:0] gyro_y_cal;
    logic signed [SAMPLE_W-1:0] gyro_z_cal;
    logic signed [SAMPLE_W-1:0] accel_x_cal;
    logic signed [SAMPLE_W-1:0] accel_y_cal;
    logic signed [SAMPLE_W-1:0] accel_z_cal;
    logic                       saturated;

    modport source (
        output valid, gyro_x_cal, gyro_y_cal, gyro_z_cal,
               accel_x_cal, accel_y_cal, accel_z_cal, saturated,
        input  ready
    );
    modport sink (
        input  valid, gyro_x_cal, gyro_y_cal, gyro_z_cal,
               accel_x_cal, accel_y_cal, accel_z_cal, saturated,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/ibsac_regs.sv
// ----------------------------------------------------------------------------
// ibsac_regs
// APB register file holding the six packed matrix rows with bias.
// ----------------------------------------------------------------------------
`default_nettype none

module ibsac_regs import ibsac_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [ROW_W-1:0]   pwdata,
    output logic      [ROW_W-1:0]   prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [IDX_W-1:0] reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[PADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_ACCEL_ROW0: cfg_next.accel[0] = pwdata;
                REG_ACCEL_ROW1: cfg_next.accel[1] = pwdata;
                REG_ACCEL_ROW2: cfg_next.accel[2] = pwdata;
                REG_GYRO_ROW0:  cfg_next.gyro[0]  = pwdata;
                REG_GYRO_ROW1:  cfg_next.gyro[1]  = pwdata;
                REG_GYRO_ROW2:  cfg_next.gyro[2]  = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ACCEL_ROW0: prdata = cfg_reg.accel[0];
            REG_ACCEL_ROW1: prdata = cfg_reg.accel[1];
            REG_ACCEL_ROW2: prdata = cfg_reg.accel[2];
            REG_GYRO_ROW0:  prdata = cfg_reg.gyro[0];
            REG_GYRO_ROW1:  prdata = cfg_reg.gyro[1];
            REG_GYRO_ROW2:  prdata = cfg_reg.gyro[2];
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel[0] <= ROW0_RESET;
            cfg_reg.accel[1] <= ROW1_RESET;
            cfg_reg.accel[2] <= ROW2_RESET;
            cfg_reg.gyro[0]  <= ROW0_RESET;
            cfg_reg.gyro[1]  <= ROW1_RESET;
            cfg_reg.gyro[2]  <= ROW2_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ibsac_lane.sv
// ----------------------------------------------------------------------------
// ibsac_lane
// One output axis: three products, then sum, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module ibsac_lane import ibsac_pkg::*; (
    input  wire logic  clk,
    input  wire logic  en_mul,
    input  wire logic  en_out,
    input  wire row_t  row,
    input  wire diff_t d [AXES],
    output sample_t    cal,
    output logic       clip
);

    logic signed [PROD_W-1:0] prod_reg  [AXES];
    logic signed [PROD_W-1:0] prod_next [AXES];
    logic signed [SUM_W-1:0]  sum;
    logic signed [RND_W-1:0]  rounded;
    logic                     fits;
    sample_t                  cal_reg;
    sample_t                  cal_next;
    logic                     clip_reg;

    always_comb
    begin
        for (int j = 0; j < AXES; j++)
        begin
            prod_next[j] = PROD_W'($signed(row[COEF_W*j +: COEF_W])) * PROD_W'(d[j]);
        end
    end

    // Add half an LSB, then floor-shift: ties go toward plus infinity
    assign sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
               + SUM_W'(ROUND_HALF);
    assign rounded = sum[SUM_W-1:FRAC_W];

    // Fits when every bit above the sample sign agrees with it
    assign fits = (&rounded[RND_W-1:SAMPLE_W-1]) || !(|rounded[RND_W-1:SAMPLE_W-1]);

    always_comb
    begin
        if (fits)
            cal_next = rounded[SAMPLE_W-1:0];
        else if (rounded[RND_W-1])
            cal_next = SAT_LO;
        else
            cal_next = SAT_HI;
    end

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            for (int j = 0; j < AXES; j++)
                prod_reg[j] <= prod_next[j];
        end
        if (en_out)
        begin
            cal_reg  <= cal_next;
            clip_reg <= !fits;
        end
    end

    assign cal  = cal_reg;
    assign clip = clip_reg;

endmodule

`default_nettype wire

FILE: rtl/imu_bias_scale_alignment_correct.sv
// Pipeline: registered bias, multiply and round stages precede result valid.
// Throughput: 1 item per cycle while the sink is ready; six lanes each own
// one output axis, and a stage takes a new item whenever its successor moves on.
// A stalled result holds in the output register; bubbles upstream still fill.
// Reset: asynchronous, active low; clears the stage valid bits and loads the
// identity matrix with zero bias into all six row registers.
// ----------------------------------------------------------------------------
// imu_bias_scale_alignment_correct
// Per-sample IMU calibration: bias subtract, 3x3 matrix, round, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_bias_scale_alignment_correct import ibsac_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ibsac_in_if.sink                sample_in,
    ibsac_out_if.source             sample_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [ROW_W-1:0]   pwdata,
    output logic      [ROW_W-1:0]   prdata,
    output logic                    pready
);

    cfg_t cfg;

    // Stage valid bits; each stage advances when empty or its successor moves
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    // Stage 1 holds bias-corrected differences for both sensors
    diff_t gyro_d_reg  [AXES];
    diff_t accel_d_reg [AXES];
    diff_t gyro_d_next [AXES];
    diff_t accel_d_next[AXES];

    sample_t gyro_cal  [AXES];
    sample_t accel_cal [AXES];
    logic    gyro_clip [AXES];
    logic    accel_clip[AXES];

    ibsac_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en3 = !v3_reg || sample_out.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign sample_in.ready = en1;

    // Subtract each axis's bias at full width; the difference is not clipped
    always_comb
    begin
        gyro_d_next[0]  = DIFF_W'(sample_in.gyro_x_raw)
                        - DIFF_W'($signed(cfg.gyro[0][BIAS_LSB +: BIAS_W]));
        gyro_d_next[1]  = DIFF_W'(sample_in.gyro_y_raw)
                        - DIFF_W'($signed(cfg.gyro[1][BIAS_LSB +: BIAS_W]));
        gyro_d_next[2]  = DIFF_W'(sample_in.gyro_z_raw)
                        - DIFF_W'($signed(cfg.gyro[2][BIAS_LSB +: BIAS_W]));
        accel_d_next[0] = DIFF_W'(sample_in.accel_x_raw)
                        - DIFF_W'($signed(cfg.accel[0][BIAS_LSB +: BIAS_W]));
        accel_d_next[1] = DIFF_W'(sample_in.accel_y_raw)
                        - DIFF_W'($signed(cfg.accel[1][BIAS_LSB +: BIAS_W]));
        accel_d_next[2] = DIFF_W'(sample_in.accel_z_raw)
                        - DIFF_W'($signed(cfg.accel[2][BIAS_LSB +: BIAS_W]));
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                gyro_d_reg[i]  <= gyro_d_next[i];
                accel_d_reg[i] <= accel_d_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= sample_in.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // One lane per output axis; every lane sees its sensor's full difference triad
    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        ibsac_lane u_gyro (
            .clk    (clk),
            .en_mul (en2),
            .en_out (en3),
            .row    (cfg.gyro[i]),
            .d      (gyro_d_reg),
            .cal    (gyro_cal[i]),
            .clip   (gyro_clip[i])
        );
        ibsac_lane u_accel (
            .clk    (clk),
            .en_mul (en2),
            .en_out (en3),
            .row    (cfg.accel[i]),
            .d      (accel_d_reg),
            .cal    (accel_cal[i]),
            .clip   (accel_clip[i])
        );
    end

    // Merge: gather lane results and fold the clip flags into one
    assign sample_out.valid       = v3_reg;
    assign sample_out.gyro_x_cal  = gyro_cal[0];
    assign sample_out.gyro_y_cal  = gyro_cal[1];
    assign sample_out.gyro_z_cal  = gyro_cal[2];
    assign sample_out.accel_x_cal = accel_cal[0];
    assign sample_out.accel_y_cal = accel_cal[1];
    assign sample_out.accel_z_cal = accel_cal[2];
    assign sample_out.saturated   = gyro_clip[0] || gyro_clip[1] || gyro_clip[2]
                                 || accel_clip[0] || accel_clip[1] || accel_clip[2];

endmodule

`default_nettype wire

FILE: rtl/ibsac_checker.sv
// ----------------------------------------------------------------------------
// ibsac_checker
// Port-level checks on the calibration block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ibsac_checker import ibsac_pkg::*; (
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_valid,
    input wire logic    in_ready,
    input wire logic    out_valid,
    input wire logic    out_ready,
    input wire sample_t gx,
    input wire sample_t gy,
    input wire sample_t gz,
    input wire sample_t ax,
    input wire sample_t ay,
    input wire sample_t az,
    input wire logic    saturated
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gx) && $stable(gy)
            && $stable(gz) && $stable(ax) && $stable(ay) && $stable(az)
            && $stable(saturated))
        else $error("result changed while stalled");

    // With the sink ready, a transfer passes every stage register to the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result missing three cycles after input transfer");

    // The flag implies at least one output sits on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            gx == SAT_HI || gx == SAT_LO || gy == SAT_HI || gy == SAT_LO
            || gz == SAT_HI || gz == SAT_LO || ax == SAT_HI || ax == SAT_LO
            || ay == SAT_HI || ay == SAT_LO || az == SAT_HI || az == SAT_LO)
        else $error("saturated flag without a clipped output");

    // An empty pipeline never blocks the input side
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

endmodule

bind imu_bias_scale_alignment_correct ibsac_checker u_ibsac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (sample_out.valid),
    .out_ready (sample_out.ready),
    .gx        (sample_out.gyro_x_cal),
    .gy        (sample_out.gyro_y_cal),
    .gz        (sample_out.gyro_z_cal),
    .ax        (sample_out.accel_x_cal),
    .ay        (sample_out.accel_y_cal),
    .az        (sample_out.accel_z_cal),
    .saturated (sample_out.saturated)
);

`default_nettype wire

FILE: sim/tb_imu_bias_scale_alignment_correct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_bias_scale_alignment_correct
// Self-checking bench for the IMU bias, scale and alignment correction block.
// A short table of directed samples runs first: reset identity, clipping,
// round-half-up ties, full-width bias difference and writes to unmapped
// registers. Ten register settings follow, each carrying a run of random
// samples. Every result is compared field by field against the table, the raw
// sample or an in-bench fixed-point calibrator. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_imu_bias_scale_alignment_correct;
    import ibsac_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int PHASE_ITEMS    = 110;
    localparam int NUM_PHASES     = 10;
    // Pipeline is three stages deep; give it a few more cycles before a write
    localparam int SETTLE_CYCLES  = 8;
    // Longest sender gap plus longest receiver stall stays well under the watchdog limit
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 40;

    localparam longint CNT_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint CNT_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

    // Indexes past the register map; writes there must leave every row alone
    localparam logic [IDX_W-1:0] REG_SPARE_A = IDX_W'(NUM_REGS);
    localparam logic [IDX_W-1:0] REG_SPARE_B = IDX_W'(NUM_REGS + 1);

    localparam logic [IDX_W-1:0] ROW_REGS [NUM_REGS] = '{
        REG_ACCEL_ROW0, REG_ACCEL_ROW1, REG_ACCEL_ROW2,
        REG_GYRO_ROW0,  REG_GYRO_ROW1,  REG_GYRO_ROW2
    };

    typedef logic signed [SAMPLE_W-1:0] count_t;
    typedef count_t [AXES-1:0]          triad_t;

    typedef struct packed {
        triad_t gyro;
        triad_t accel;
    } raw_pair_t;

    typedef struct packed {
        triad_t gyro;
        triad_t accel;
        logic   saturated;
    } cal_pair_t;

    // How the expected result of a sample is obtained
    typedef enum logic [1:0] {
        CHK_MODEL,  // from the calibrator below
        CHK_ECHO,   // identity setting: result equals the raw sample
        CHK_GIVEN   // typed into the table
    } chk_kind_t;

    typedef struct packed {
        logic      load_corner;
        chk_kind_t kind;
        raw_pair_t raw;
        cal_pair_t want;
    } dir_row_t;

    typedef enum logic [2:0] {
        CFG_NEAR_IDENTITY,
        CFG_PURE_BIAS,
        CFG_FULL_RANDOM,
        CFG_ALL_ZERO,
        CFG_ALL_ONES,
        CFG_MOST_POSITIVE,
        CFG_MOST_NEGATIVE
    } cfg_style_t;

    localparam cfg_style_t PHASE_PLAN [NUM_PHASES] = '{
        CFG_NEAR_IDENTITY, CFG_FULL_RANDOM, CFG_MOST_POSITIVE, CFG_NEAR_IDENTITY,
        CFG_MOST_NEGATIVE, CFG_PURE_BIAS,   CFG_ALL_ONES,      CFG_FULL_RANDOM,
        CFG_ALL_ZERO,      CFG_NEAR_IDENTITY
    };

    // Corner setting: gyro matrix is -2.0 on the diagonal, so large inputs
    // clip both ways; accel matrix is 0.5 on the diagonal, so odd inputs land
    // exactly halfway; accel z carries the most negative bias, so its
    // difference needs the 17th bit.
    localparam row_t CORNER_ROWS [NUM_REGS] = '{
        64'h0000_0000_0000_2000, 64'h0000_0000_2000_0000, 64'h8000_2000_0000_0000,
        64'h0000_0000_0000_8000, 64'h0000_0000_8000_0000, 64'h0000_8000_0000_0000
    };

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [ROW_W-1:0]   pwdata;
    logic [ROW_W-1:0]   prdata;
    logic               pready;

    ibsac_in_if  sample_in_if ();
    ibsac_out_if sample_out_if ();

    imu_bias_scale_alignment_correct i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in_if),
        .sample_out (sample_out_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow of the six row registers, as the block should hold them
    row_t [AXES-1:0] accel_cfg;
    row_t [AXES-1:0] gyro_cfg;

    // Calibrated results owed by the block, oldest first
    cal_pair_t pending_cal [$];

    // Sideband of the sample on the input channel: driven with the payload
    chk_kind_t next_kind;
    cal_pair_t next_given;

    logic idle_on;
    int   errors;
    int   samples_in;
    int   results_seen;
    int   clipped_seen;
    int   cfg_writes;
    int   quiet_cycles;

    // ------------------------------------------------------------------------
    // Calibrator
    // ------------------------------------------------------------------------

    // Subtract bias, apply one 3x3 row set, round half up, clip to counts
    function automatic void correct_triad(input row_t [AXES-1:0] rows, input triad_t raw,
                                          output triad_t cal, inout logic clip);
        longint diff [AXES];
        longint acc;
        longint q;
        // Bias of axis j lives in row j; the difference keeps its full width
        for (int j = 0; j < AXES; j++)
            diff[j] = longint'($signed(raw[j]))
                    - longint'($signed(rows[j][BIAS_LSB +: BIAS_W]));
        for (int i = 0; i < AXES; i++)
        begin
            acc = 0;
            for (int j = 0; j < AXES; j++)
                acc += longint'($signed(rows[i][COEF_W*j +: COEF_W])) * diff[j];
            // Arithmetic shift floors, so adding half first rounds ties up
            q = (acc + ROUND_HALF) >>> FRAC_W;
            if (q > CNT_MAX)
            begin
                q    = CNT_MAX;
                clip = 1'b1;
            end
            else if (q < CNT_MIN)
            begin
                q    = CNT_MIN;
                clip = 1'b1;
            end
            cal[i] = q[SAMPLE_W-1:0];
        end
    endfunction

    function automatic cal_pair_t calibrate(input raw_pair_t raw);
        cal_pair_t res;
        logic      clip;
        clip = 1'b0;
        correct_triad(gyro_cfg, raw.gyro, res.gyro, clip);
        correct_triad(accel_cfg, raw.accel, res.accel, clip);
        res.saturated = clip;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic count_t rand_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            return count_t'($urandom);
        if (pick <= 7)
            return count_t'(int'($urandom_range(0, 1024)) - 512);
        if (pick == 8)
        begin
            case ($urandom_range(0, 4))
                0:       return count_t'(CNT_MIN);
                1:       return count_t'(CNT_MAX);
                2:       return count_t'(-1);
                3:       return count_t'(1);
                default: return count_t'(0);
            endcase
        end
        // Large magnitudes, where the matrix gain pushes toward the rails
        if ($urandom_range(0, 1) == 0)
            return count_t'(int'($urandom_range(16384, 32767)));
        return count_t'(-int'($urandom_range(16384, 32768)));
    endfunction

    function automatic row_t make_row(input cfg_style_t style, input int axis);
        row_t r;
        r = '0;
        case (style)
            CFG_NEAR_IDENTITY:
            begin
                // Small misalignment and scale error, modest bias
                for (int k = 0; k < AXES; k++)
                    r[COEF_W*k +: COEF_W] = (k == axis)
                        ? COEF_W'(16384 + int'($urandom_range(0, 4000)) - 2000)
                        : COEF_W'(int'($urandom_range(0, 3000)) - 1500);
                r[BIAS_LSB +: BIAS_W] = BIAS_W'(int'($urandom_range(0, 1200)) - 600);
            end
            CFG_PURE_BIAS:
            begin
                r[COEF_W*axis +: COEF_W] = COEF_W'(16384);
                r[BIAS_LSB +: BIAS_W]    = BIAS_W'($urandom);
            end
            CFG_FULL_RANDOM:   r = {$urandom, $urandom};
            CFG_ALL_ONES:      r = '1;
            CFG_MOST_POSITIVE: r = {4{16'h7FFF}};
            CFG_MOST_NEGATIVE: r = {4{16'h8000}};
            default:           r = '0;
        endcase
        return r;
    endfunction

    function automatic dir_row_t drow(input logic load_corner, input chk_kind_t kind,
                                      input int gx, input int gy, input int gz,
                                      input int ax, input int ay, input int az,
                                      input int wgx = 0, input int wgy = 0,
                                      input int wgz = 0, input int wax = 0,
                                      input int way = 0, input int waz = 0,
                                      input logic wsat = 1'b0);
        dir_row_t row;
        row.load_corner     = load_corner;
        row.kind            = kind;
        row.raw.gyro        = {count_t'(gz), count_t'(gy), count_t'(gx)};
        row.raw.accel       = {count_t'(az), count_t'(ay), count_t'(ax)};
        row.want.gyro       = {count_t'(wgz), count_t'(wgy), count_t'(wgx)};
        row.want.accel      = {count_t'(waz), count_t'(way), count_t'(wax)};
        row.want.saturated  = wsat;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    // Print only the first few mismatches; count them all
    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic check_cal(input cal_pair_t want, input cal_pair_t got);
        string axis_tag [AXES] = '{"x", "y", "z"};
        for (int i = 0; i < AXES; i++)
        begin
            if (got.gyro[i] !== want.gyro[i])
                report_mismatch($sformatf("result %0d: gyro_%s_cal = %0d, want %0d",
                    results_seen, axis_tag[i], $signed(got.gyro[i]),
                    $signed(want.gyro[i])));
            if (got.accel[i] !== want.accel[i])
                report_mismatch($sformatf("result %0d: accel_%s_cal = %0d, want %0d",
                    results_seen, axis_tag[i], $signed(got.accel[i]),
                    $signed(want.accel[i])));
        end
        if (got.saturated !== want.saturated)
            report_mismatch($sformatf("result %0d: saturated = %b, want %b",
                results_seen, got.saturated, want.saturated));
    endtask

    // ------------------------------------------------------------------------
    // Bus and channel drivers
    // ------------------------------------------------------------------------

    // Write one row register, then read it back where it is mapped
    task automatic load_row(input logic [IDX_W-1:0] idx, input row_t value);
        logic mapped;
        mapped = (idx < IDX_W'(NUM_REGS));
        // Setup phase; rows are 64 bits wide, so they sit 8 bytes apart
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ACCEL_ROW0: accel_cfg[0] = value;
            REG_ACCEL_ROW1: accel_cfg[1] = value;
            REG_ACCEL_ROW2: accel_cfg[2] = value;
            REG_GYRO_ROW0:  gyro_cfg[0]  = value;
            REG_GYRO_ROW1:  gyro_cfg[1]  = value;
            REG_GYRO_ROW2:  gyro_cfg[2]  = value;
            default:        ;
        endcase
        cfg_writes++;
        if (mapped)
        begin
            // Hold psel and the address, start a read transfer
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata !== value)
                report_mismatch($sformatf("row register %0d reads %h, want %h",
                    idx, prdata, value));
        end
        // Return the bus to idle before the next transfer
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Present one sample after a random gap and hold it until its transfer
    task automatic send_sample(input raw_pair_t raw, input chk_kind_t kind,
                               input cal_pair_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_in_if.valid       <= 1'b1;
        sample_in_if.gyro_x_raw  <= raw.gyro[0];
        sample_in_if.gyro_y_raw  <= raw.gyro[1];
        sample_in_if.gyro_z_raw  <= raw.gyro[2];
        sample_in_if.accel_x_raw <= raw.accel[0];
        sample_in_if.accel_y_raw <= raw.accel[1];
        sample_in_if.accel_z_raw <= raw.accel[2];
        next_kind                <= kind;
        next_given               <= want;
        do @(posedge clk); while (!sample_in_if.ready);
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic drain_results();
        sample_in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_cal.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Result receiver: stall at random while idling is on
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left          = 0;
        sample_out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap();
            sample_out_if.ready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every sample transfer, check every result transfer.
    // Values read here are the ones that stood before the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        raw_pair_t raw;
        cal_pair_t got;
        logic      active;
        if (rst_n)
        begin
            active = psel;
            if (sample_in_if.valid && sample_in_if.ready)
            begin
                active       = 1'b1;
                raw.gyro[0]  = sample_in_if.gyro_x_raw;
                raw.gyro[1]  = sample_in_if.gyro_y_raw;
                raw.gyro[2]  = sample_in_if.gyro_z_raw;
                raw.accel[0] = sample_in_if.accel_x_raw;
                raw.accel[1] = sample_in_if.accel_y_raw;
                raw.accel[2] = sample_in_if.accel_z_raw;
                case (next_kind)
                    CHK_ECHO:  pending_cal.push_back('{gyro: raw.gyro, accel: raw.accel,
                                                       saturated: 1'b0});
                    CHK_GIVEN: pending_cal.push_back(next_given);
                    default:   pending_cal.push_back(calibrate(raw));
                endcase
                samples_in++;
            end
            if (sample_out_if.valid && sample_out_if.ready)
            begin
                active        = 1'b1;
                got.gyro[0]   = sample_out_if.gyro_x_cal;
                got.gyro[1]   = sample_out_if.gyro_y_cal;
                got.gyro[2]   = sample_out_if.gyro_z_cal;
                got.accel[0]  = sample_out_if.accel_x_cal;
                got.accel[1]  = sample_out_if.accel_y_cal;
                got.accel[2]  = sample_out_if.accel_z_cal;
                got.saturated = sample_out_if.saturated;
                if (pending_cal.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with no sample owed",
                        results_seen));
                else
                    check_cal(pending_cal.pop_front(), got);
                results_seen++;
                if (got.saturated === 1'b1)
                    clipped_seen++;
            end
            // Watchdog: end the run when nothing has moved for too long
            if (active)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results owed",
                    quiet_cycles, pending_cal.size());
                $display("tb_imu_bias_scale_alignment_correct failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        dir_row_t  directed [$];
        raw_pair_t raw;

        // Known values on every block input from time zero
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        sample_in_if.valid       = 1'b0;
        sample_in_if.gyro_x_raw  = '0;
        sample_in_if.gyro_y_raw  = '0;
        sample_in_if.gyro_z_raw  = '0;
        sample_in_if.accel_x_raw = '0;
        sample_in_if.accel_y_raw = '0;
        sample_in_if.accel_z_raw = '0;
        next_kind                = CHK_MODEL;
        next_given               = '0;
        idle_on                  = 1'b1;
        errors                   = 0;
        samples_in               = 0;
        results_seen             = 0;
        clipped_seen             = 0;
        cfg_writes               = 0;
        quiet_cycles             = 0;
        accel_cfg                = {ROW2_RESET, ROW1_RESET, ROW0_RESET};
        gyro_cfg                 = {ROW2_RESET, ROW1_RESET, ROW0_RESET};

        // Under the reset identity with zero bias, every sample comes back as is
        directed.push_back(drow(1'b0, CHK_ECHO, 0, 0, 0, 0, 0, 0));
        directed.push_back(drow(1'b0, CHK_ECHO, 32767, 32767, 32767, 32767, 32767, 32767));
        directed.push_back(drow(1'b0, CHK_ECHO, -32768, -32768, -32768,
                                -32768, -32768, -32768));
        directed.push_back(drow(1'b0, CHK_ECHO, 32767, -32768, -1, 1, 21845, -21846));
        directed.push_back(drow(1'b0, CHK_ECHO, -21846, 21845, 1, -1, -32768, 32767));
        directed.push_back(drow(1'b0, CHK_ECHO, -1, -1, -1, -1, -1, -1));
        directed.push_back(drow(1'b0, CHK_MODEL, 1234, -5678, 9012, -3456, 7890, -12));
        // Corner setting: gyro = sat(-2 * raw), accel = round_up(raw / 2) on x, y
        // and accel z = round_up((raw + 32768) / 2)
        directed.push_back(drow(1'b1, CHK_GIVEN, 0, 0, 0, 0, 0, -32768,
                                0, 0, 0, 0, 0, 0, 1'b0));
        // Halfway cases: +0.5 goes to 1, -0.5 goes to 0
        directed.push_back(drow(1'b0, CHK_GIVEN, 1, -1, 0, 1, -1, -32768,
                                -2, 2, 0, 1, 0, 0, 1'b0));
        directed.push_back(drow(1'b0, CHK_GIVEN, 3, -3, 16383, 3, -3, -32768,
                                -6, 6, -32766, 2, -1, 0, 1'b0));
        // Lower rail is reached exactly, upper rail clips
        directed.push_back(drow(1'b0, CHK_GIVEN, 16384, -16384, 0, 0, 0, -32768,
                                -32768, 32767, 0, 0, 0, 0, 1'b1));
        // Both rails clip on gyro; full-width bias difference clips accel z
        directed.push_back(drow(1'b0, CHK_GIVEN, -32768, 32767, 0, 32767, -32768, 32767,
                                32767, -32768, 0, 16384, -16384, 32767, 1'b1));
        directed.push_back(drow(1'b0, CHK_MODEL, 12345, -2222, 777, -9999, 31000, -1));

        // Reset: hold rst_n low for a fixed count, then release on an edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
        begin
            if (directed[n].load_corner)
            begin
                drain_results();
                // Unmapped indexes first: the corner rows below must still hold
                load_row(REG_SPARE_A, '1);
                load_row(REG_SPARE_B, '1);
                for (int k = 0; k < NUM_REGS; k++)
                    load_row(ROW_REGS[k], CORNER_ROWS[k]);
            end
            send_sample(directed[n].raw, directed[n].kind, directed[n].want);
        end

        // Random part: one register setting per phase, random samples under it
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            for (int k = 0; k < NUM_REGS; k++)
                load_row(ROW_REGS[k], make_row(PHASE_PLAN[ph], k % AXES));
            if (ph % 3 == 0)
            begin
                load_row(REG_SPARE_A, {$urandom, $urandom});
                load_row(REG_SPARE_B, {$urandom, $urandom});
            end
            // Every fourth phase runs back to back with no idling on either side
            idle_on <= (ph % 4 != 1);
            repeat (PHASE_ITEMS)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    raw.gyro[a]  = rand_count();
                    raw.accel[a] = rand_count();
                end
                send_sample(raw, CHK_MODEL, '0);
            end
        end

        drain_results();

        $display("%0d samples under %0d settings and %0d register writes",
            samples_in, NUM_PHASES + 2, cfg_writes);
        $display("%0d results compared, %0d of them clipped, %0d mismatches",
            results_seen, clipped_seen, errors);
        if (errors == 0)
            $display("tb_imu_bias_scale_alignment_correct passed");
        else
            $display("tb_imu_bias_scale_alignment_correct failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ibsac_pkg.sv
rtl/ibsac_if.sv
rtl/ibsac_regs.sv
rtl/ibsac_lane.sv
rtl/imu_bias_scale_alignment_correct.sv
rtl/ibsac_checker.sv
sim/tb_imu_bias_scale_alignment_correct.sv
